// ----- rtl/core/ramped_coefficient_biquad_macros.svh -----
// Assertion macros used by the ramped coefficient biquad top level.
`ifndef RAMPED_COEFFICIENT_BIQUAD_MACROS_SVH
`define RAMPED_COEFFICIENT_BIQUAD_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define RCBQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define RCBQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rcbq_pkg.sv -----
// Package: shared constants, codes and types of the ramped coefficient biquad.
`timescale 1ns / 1ps
package rcbq_pkg;

    // Coefficient slots: a1, a2, b1, b2
    localparam int NUM_COEFS     = 4;
    localparam int COEF_IDX_BITS = 2;
    localparam int COEF_A1       = 0;
    localparam int COEF_A2       = 1;
    localparam int COEF_B1       = 2;
    localparam int COEF_B2       = 3;

    // Ramp shift register width
    localparam int SHIFT_BITS = 4;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_A1  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_A2  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_B1  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_B2  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP_SHIFT = 3'd4;
    localparam logic [SHIFT_BITS-1:0]     RAMP_SHIFT_RESET = 4'd8;

    // Operation codes of an input item
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Per-cycle commands to the coefficient ramp
    typedef struct packed {
        logic sample_go;   // a sample item leaves the input register
        logic update_go;   // an update item leaves the input register
    } ramp_ctrl_t;

endpackage

// ----- rtl/core/rcbq_if.sv -----
// Interfaces: sample input, result output and configuration write channels.
`timescale 1ns / 1ps
interface rcbq_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output operation, output sample_in, input ready);
    modport sink   (input valid, input operation, input sample_in, output ready);
endinterface

interface rcbq_out_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface rcbq_cfg_if #(parameter int COEF_BITS = 32);
    logic                                  valid;
    logic                                  ready;
    logic [rcbq_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [COEF_BITS-1:0]                  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/rcbq_ramp.sv -----
// Coefficient ramp: current coefficients, per-sample steps and saturating updates.
`timescale 1ns / 1ps
module rcbq_ramp #(
    parameter int COEF_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rcbq_pkg::ramp_ctrl_t              ctrl,
    input  logic signed [COEF_BITS-1:0]       target [rcbq_pkg::NUM_COEFS],
    input  logic [rcbq_pkg::SHIFT_BITS-1:0]   ramp_shift,
    output logic signed [COEF_BITS-1:0]       coef_stepped [rcbq_pkg::NUM_COEFS]
);
    import rcbq_pkg::*;

    logic signed [COEF_BITS-1:0] coef_now_reg  [NUM_COEFS];
    logic signed [COEF_BITS-1:0] coef_step_reg [NUM_COEFS];
    logic signed [COEF_BITS-1:0] step_next     [NUM_COEFS];
    logic signed [COEF_BITS:0]   stepped_sum   [NUM_COEFS];
    logic signed [COEF_BITS:0]   diff          [NUM_COEFS];
    logic signed [COEF_BITS:0]   diff_shifted  [NUM_COEFS];

    // Step each coefficient, saturating to the coefficient range
    always_comb
    begin
        for (int k = 0; k < NUM_COEFS; k++)
        begin
            stepped_sum[k] = (COEF_BITS+1)'(coef_now_reg[k]) + (COEF_BITS+1)'(coef_step_reg[k]);
            if (stepped_sum[k][COEF_BITS] != stepped_sum[k][COEF_BITS-1])
            begin
                coef_stepped[k] = {stepped_sum[k][COEF_BITS], {(COEF_BITS-1){~stepped_sum[k][COEF_BITS]}}};
            end
            else
            begin
                coef_stepped[k] = stepped_sum[k][COEF_BITS-1:0];
            end
        end
    end

    // Compute new steps: (target - current) >>> shift, saturated
    always_comb
    begin
        for (int k = 0; k < NUM_COEFS; k++)
        begin
            diff[k]         = (COEF_BITS+1)'(target[k]) - (COEF_BITS+1)'(coef_now_reg[k]);
            diff_shifted[k] = diff[k] >>> ramp_shift;
            if (diff_shifted[k][COEF_BITS] != diff_shifted[k][COEF_BITS-1])
            begin
                step_next[k] = {diff_shifted[k][COEF_BITS], {(COEF_BITS-1){~diff_shifted[k][COEF_BITS]}}};
            end
            else
            begin
                step_next[k] = diff_shifted[k][COEF_BITS-1:0];
            end
        end
    end

    // Hold coefficient state; advance on sample, restart ramp on update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COEFS; k++)
            begin
                coef_now_reg[k]  <= '0;
                coef_step_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < NUM_COEFS; k++)
            begin
                if (ctrl.sample_go)
                begin
                    coef_now_reg[k] <= coef_stepped[k];
                end
                if (ctrl.update_go)
                begin
                    coef_step_reg[k] <= step_next[k];
                end
            end
        end
    end

endmodule

// ----- rtl/core/rcbq_mac.sv -----
// Filter datapath: four products plus the input term, rounding and saturation.
`timescale 1ns / 1ps
module rcbq_mac #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32
) (
    input  logic signed [COEF_BITS-1:0]   coef [rcbq_pkg::NUM_COEFS],
    input  logic signed [SAMPLE_BITS-1:0] hist [rcbq_pkg::NUM_COEFS],
    input  logic signed [SAMPLE_BITS-1:0] x,
    output logic signed [SAMPLE_BITS-1:0] y
);
    import rcbq_pkg::*;

    localparam int FRAC_BITS = COEF_BITS - 3;
    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;
    localparam int RND_BITS  = ACC_BITS - FRAC_BITS;
    localparam int TOP_BITS  = RND_BITS - SAMPLE_BITS + 1;

    logic signed [PROD_BITS-1:0] prod [NUM_COEFS];
    logic signed [ACC_BITS-1:0]  acc;
    logic signed [ACC_BITS-1:0]  acc_rounded;
    logic signed [RND_BITS-1:0]  rounded;
    logic [TOP_BITS-1:0]         top_bits;

    // Multiply each coefficient with its history tap
    always_comb
    begin
        for (int k = 0; k < NUM_COEFS; k++)
        begin
            prod[k] = PROD_BITS'(coef[k]) * PROD_BITS'(hist[k]);
        end
    end

    // Sum the products with the input scaled to the coefficient fraction
    always_comb
    begin
        acc = ACC_BITS'(x) <<< FRAC_BITS;
        for (int k = 0; k < NUM_COEFS; k++)
        begin
            acc = acc + ACC_BITS'(prod[k]);
        end
        acc_rounded = acc + (ACC_BITS'(1) <<< (FRAC_BITS - 1));
        rounded     = acc_rounded[ACC_BITS-1:FRAC_BITS];
        top_bits    = rounded[RND_BITS-1:SAMPLE_BITS-1];
    end

    // Saturate to the sample range
    always_comb
    begin
        if ((&top_bits) || !(|top_bits))
        begin
            y = rounded[SAMPLE_BITS-1:0];
        end
        else
        begin
            y = {rounded[RND_BITS-1], {(SAMPLE_BITS-1){~rounded[RND_BITS-1]}}};
        end
    end

endmodule

// ----- rtl/core/ramped_coefficient_biquad.sv -----
// Top level: biquad section with ramped coefficients, channel control and state.
//
//  channel   role   transfer content
//  -------   ----   -------------------------------------
//  samples   sink   operation, sample_in
//  results   source sample_out (one per filter item)
//  cfg       sink   index, data (register write)
//
// An item enters the input register on its transfer and a filter item's result is then
// loaded into the output register; one item per cycle while no result waits on results.ready.
// The rate is set by the combinational recursion through four multipliers and the
// sum feeding prev_out_1. Update items leave the input register without using the
// output register. A result waiting on results.ready stalls only filter items.
// Reset clears history, coefficients and steps, targets to 0 and ramp_shift to 8.
`timescale 1ns / 1ps
module ramped_coefficient_biquad #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    rcbq_in_if.sink     samples,
    rcbq_out_if.source  results,
    rcbq_cfg_if.sink    cfg
);
    import rcbq_pkg::*;
    `include "ramped_coefficient_biquad_macros.svh"

    // Input register
    logic                          in_valid_reg;
    logic                          in_op_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;

    // Output register
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    // Sample history
    logic signed [SAMPLE_BITS-1:0] prev_out_1_reg;
    logic signed [SAMPLE_BITS-1:0] prev_out_2_reg;
    logic signed [SAMPLE_BITS-1:0] prev_in_1_reg;
    logic signed [SAMPLE_BITS-1:0] prev_in_2_reg;

    // Configuration
    logic signed [COEF_BITS-1:0]   target_reg [NUM_COEFS];
    logic [SHIFT_BITS-1:0]         ramp_shift_reg;

    logic                          out_free;
    logic                          in_advance;
    ramp_ctrl_t                    ramp_ctrl;
    logic signed [COEF_BITS-1:0]   coef_stepped [NUM_COEFS];
    logic signed [SAMPLE_BITS-1:0] hist [NUM_COEFS];
    logic signed [SAMPLE_BITS-1:0] y_next;

    // Handshake control
    assign out_free            = !out_valid_reg || results.ready;
    assign in_advance          = in_valid_reg && ((in_op_reg == OP_UPDATE) || out_free);
    assign samples.ready       = !in_valid_reg || in_advance;
    assign ramp_ctrl.sample_go = in_advance && (in_op_reg == OP_FILTER);
    assign ramp_ctrl.update_go = in_advance && (in_op_reg == OP_UPDATE);
    assign cfg.ready           = 1'b1;
    assign results.valid       = out_valid_reg;
    assign results.sample_out  = sample_out_reg;

    // Route history taps to their coefficients
    assign hist[COEF_A1] = prev_out_1_reg;
    assign hist[COEF_A2] = prev_out_2_reg;
    assign hist[COEF_B1] = prev_in_1_reg;
    assign hist[COEF_B2] = prev_in_2_reg;

    rcbq_ramp #(
        .COEF_BITS (COEF_BITS)
    ) u_ramp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ramp_ctrl),
        .target       (target_reg),
        .ramp_shift   (ramp_shift_reg),
        .coef_stepped (coef_stepped)
    );

    rcbq_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .coef (coef_stepped),
        .hist (hist),
        .x    (in_sample_reg),
        .y    (y_next)
    );

    // Valid flags, history and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_out_1_reg <= '0;
            prev_out_2_reg <= '0;
            prev_in_1_reg  <= '0;
            prev_in_2_reg  <= '0;
            ramp_shift_reg <= RAMP_SHIFT_RESET;
            for (int k = 0; k < NUM_COEFS; k++)
            begin
                target_reg[k] <= '0;
            end
        end
        else
        begin
            if (samples.ready)
            begin
                in_valid_reg <= samples.valid;
            end
            if (ramp_ctrl.sample_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ramp_ctrl.sample_go)
            begin
                prev_out_1_reg <= y_next;
                prev_out_2_reg <= prev_out_1_reg;
                prev_in_1_reg  <= in_sample_reg;
                prev_in_2_reg  <= prev_in_1_reg;
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_TARGET_A1,
                    REG_TARGET_A2,
                    REG_TARGET_B1,
                    REG_TARGET_B2:  target_reg[cfg.index[COEF_IDX_BITS-1:0]] <= cfg.data;
                    REG_RAMP_SHIFT: ramp_shift_reg <= cfg.data[SHIFT_BITS-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // Payload registers: load input on transfer, result on filter advance
    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            in_op_reg     <= samples.operation;
            in_sample_reg <= samples.sample_in;
        end
        if (ramp_ctrl.sample_go)
        begin
            sample_out_reg <= y_next;
        end
    end

    // Checks
    `RCBQ_ASSERT_NEXT(a_result_is_history, ramp_ctrl.sample_go,
        out_valid_reg && (sample_out_reg == prev_out_1_reg), "result differs from kept output")
    `RCBQ_ASSERT_SAME(a_no_result_overwrite, out_valid_reg && !results.ready,
        !ramp_ctrl.sample_go, "pending result overwritten")
    `RCBQ_ASSERT_NEXT(a_update_keeps_history, ramp_ctrl.update_go,
        $stable(prev_in_1_reg) && $stable(prev_out_1_reg), "update item changed history")

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the ramped coefficient biquad section.
`timescale 1ns / 1ps
module testbench;
    import rcbq_pkg::*;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int FRAC_W   = COEF_W - 3;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'((1 <<< (SAMPLE_W - 1)) - 1);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_W'(-(1 <<< (SAMPLE_W - 1)));
    localparam longint COEF_MAX = (longint'(1) <<< (COEF_W - 1)) - 1;
    localparam longint COEF_MIN = -COEF_MAX - 1;
    localparam longint Q_ONE    = longint'(1) <<< FRAC_W;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_FIRST = REG_RAMP_SHIFT + 1'b1;
    localparam int CFG_INDEX_COUNT = 1 << CFG_INDEX_BITS;

    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 136;
    localparam int DRAIN_CYCLES    = 8;
    localparam int FINAL_WAIT_MAX  = 5000;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int REPORT_MAX      = 30;

    typedef struct {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample;
    } sample_item_t;

    logic clk = 1'b0;
    logic rst_n;

    rcbq_in_if  #(.SAMPLE_BITS(SAMPLE_W)) samples_ch ();
    rcbq_out_if #(.SAMPLE_BITS(SAMPLE_W)) results_ch ();
    rcbq_cfg_if #(.COEF_BITS(COEF_W))     cfg_ch ();

    ramped_coefficient_biquad #(
        .SAMPLE_BITS(SAMPLE_W),
        .COEF_BITS(COEF_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples_ch),
        .results(results_ch),
        .cfg(cfg_ch)
    );

    // Predicted filter state and configuration
    longint      coef_cur[NUM_COEFS];
    longint      coef_inc[NUM_COEFS];
    longint      coef_goal[NUM_COEFS];
    int unsigned shift_cfg;
    longint      hist_y1, hist_y2, hist_x1, hist_x2;

    sample_item_t               pending_items[$];
    logic signed [SAMPLE_W-1:0] expected_samples[$];
    sample_item_t               next_item;
    logic signed [SAMPLE_W-1:0] want_sample;
    longint                     next_goal[NUM_COEFS];

    int items_in_flight = 0;
    int send_gap        = 0;
    int stall_left      = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int errors          = 0;
    int filtered_count  = 0;
    int update_count    = 0;
    int reg_writes      = 0;
    int settings_count  = 0;
    int cycle_count     = 0;

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic longint clamp_signed(input longint v, input int bits);
        longint hi_lim;
        longint lo_lim;
        hi_lim = (longint'(1) <<< (bits - 1)) - 1;
        lo_lim = -hi_lim - 1;
        if (v > hi_lim)
            return hi_lim;
        if (v < lo_lim)
            return lo_lim;
        return v;
    endfunction

    // Advance the predicted filter by one accepted item
    task automatic biquad_predict(input logic op, input logic signed [SAMPLE_W-1:0] x);
        longint acc;
        longint y;
        if (op == OP_UPDATE)
        begin
            for (int k = 0; k < NUM_COEFS; k++)
                coef_inc[k] = clamp_signed((coef_goal[k] - coef_cur[k]) >>> shift_cfg, COEF_W);
            update_count++;
        end
        else
        begin
            for (int k = 0; k < NUM_COEFS; k++)
                coef_cur[k] = clamp_signed(coef_cur[k] + coef_inc[k], COEF_W);
            acc = (longint'(x) <<< FRAC_W)
                + coef_cur[COEF_A1] * hist_y1 + coef_cur[COEF_A2] * hist_y2
                + coef_cur[COEF_B1] * hist_x1 + coef_cur[COEF_B2] * hist_x2;
            y = clamp_signed((acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W, SAMPLE_W);
            expected_samples.push_back(y[SAMPLE_W-1:0]);
            hist_y2 = hist_y1;
            hist_y1 = y;
            hist_x2 = hist_x1;
            hist_x1 = longint'(x);
            filtered_count++;
        end
    endtask

    // Sample driver: hold each item until its transfer, idle in random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            samples_ch.valid <= 1'b0;
        else
        begin
            if (samples_ch.valid && samples_ch.ready)
            begin
                biquad_predict(samples_ch.operation, samples_ch.sample_in);
                items_in_flight--;
                if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
                    send_gap = $urandom_range(1, 18);
            end
            if (samples_ch.valid && !samples_ch.ready)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                samples_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                next_item = pending_items.pop_front();
                samples_ch.valid     <= 1'b1;
                samples_ch.operation <= next_item.op;
                samples_ch.sample_in <= next_item.sample;
            end
            else
                samples_ch.valid <= 1'b0;
        end
    end

    // Result monitor: check each transfer, stall in random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            results_ch.ready <= 1'b0;
        else
        begin
            if (results_ch.valid && results_ch.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("%0t: sample_out expected none, got %0d",
                                 $time, results_ch.sample_out);
                end
                else
                begin
                    want_sample = expected_samples.pop_front();
                    if (results_ch.sample_out !== want_sample)
                    begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display("%0t: sample_out expected %0d, got %0d",
                                     $time, want_sample, results_ch.sample_out);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                results_ch.ready <= 1'b0;
            end
            else if (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct)
            begin
                stall_left = $urandom_range(0, 17);
                results_ch.ready <= 1'b0;
            end
            else
                results_ch.ready <= 1'b1;
        end
    end

    task automatic queue_item(input logic op, input logic signed [SAMPLE_W-1:0] x);
        sample_item_t it;
        it.op     = op;
        it.sample = x;
        pending_items.push_back(it);
        items_in_flight++;
    endtask

    // Write one register; returns in the cycle after the transfer, with valid dropped
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [COEF_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (32'(idx) < NUM_COEFS)
            coef_goal[idx[COEF_IDX_BITS-1:0]] = longint'($signed(value));
        else if (idx == REG_RAMP_SHIFT)
            shift_cfg = 32'(value[SHIFT_BITS-1:0]);
        reg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_targets(input longint t_a1, input longint t_a2,
                                 input longint t_b1, input longint t_b2);
        write_reg(REG_TARGET_A1, t_a1[COEF_W-1:0]);
        write_reg(REG_TARGET_A2, t_a2[COEF_W-1:0]);
        write_reg(REG_TARGET_B1, t_b1[COEF_W-1:0]);
        write_reg(REG_TARGET_B2, t_b2[COEF_W-1:0]);
        settings_count++;
    endtask

    task automatic write_shift(input int unsigned sh);
        logic [COEF_W-1:0] word;
        word = $urandom;
        word[SHIFT_BITS-1:0] = sh[SHIFT_BITS-1:0];
        write_reg(REG_RAMP_SHIFT, word);
    endtask

    // Wait until every item has transferred and every result has come back
    task automatic settle();
        while (items_in_flight != 0 || expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int mode);
        case (mode)
            1: return SAMPLE_W'($urandom_range(0, 131072) - 65536);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '0;
                    3: return '1;
                    default: return SAMPLE_W'($urandom);
                endcase
            end
            3: return SAMPLE_W'($urandom_range(0, 64) - 32);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic longint pick_extreme_coef();
        case ($urandom_range(0, 4))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return longint'(0);
            3: return longint'(-1);
            default: return Q_ONE;
        endcase
    endfunction

    // Choose targets: mostly a stable resonator, sometimes anything at all
    task automatic configure_random();
        int     style;
        longint r_q;
        longint a1_lim;
        style = $urandom_range(0, 9);
        if (style < 7)
        begin
            r_q = longint'($urandom_range(32'(Q_ONE / 2), 32'((Q_ONE * 999) / 1000)));
            a1_lim = (2 * r_q * 31) / 32;
            next_goal[COEF_A1] = longint'($urandom_range(0, 32'(2 * a1_lim))) - a1_lim;
            next_goal[COEF_A2] = -((r_q * r_q) >>> FRAC_W);
            next_goal[COEF_B1] = longint'($urandom_range(0, 32'(2 * Q_ONE))) - Q_ONE;
            next_goal[COEF_B2] = longint'($urandom_range(0, 32'(2 * Q_ONE))) - Q_ONE;
        end
        else if (style < 9)
        begin
            for (int k = 0; k < NUM_COEFS; k++)
                next_goal[k] = longint'($signed($urandom));
        end
        else
        begin
            for (int k = 0; k < NUM_COEFS; k++)
                next_goal[k] = pick_extreme_coef();
        end
        write_targets(next_goal[COEF_A1], next_goal[COEF_A2],
                      next_goal[COEF_B1], next_goal[COEF_B2]);
        if ($urandom_range(0, 7) == 0)
            write_shift($urandom_range(13, 15));
        else
            write_shift($urandom_range(0, 12));
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_INDEX_BITS'($urandom_range(32'(REG_SPARE_FIRST),
                                                     CFG_INDEX_COUNT - 1)), $urandom);
    endtask

    // Stimulus
    initial
    begin
        int mode;
        int spins;

        samples_ch.valid     = 1'b0;
        samples_ch.operation = OP_FILTER;
        samples_ch.sample_in = '0;
        results_ch.ready     = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        rst_n                = 1'b0;
        for (int k = 0; k < NUM_COEFS; k++)
        begin
            coef_cur[k]  = 0;
            coef_inc[k]  = 0;
            coef_goal[k] = 0;
        end
        shift_cfg = 32'(RAMP_SHIFT_RESET);
        hist_y1 = 0;
        hist_y2 = 0;
        hist_x1 = 0;
        hist_x2 = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: zero coefficients pass the input straight through
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        queue_item(OP_FILTER, SAMPLE_MAX);
        queue_item(OP_FILTER, SAMPLE_MIN);
        queue_item(OP_FILTER, '0);
        queue_item(OP_FILTER, '1);
        queue_item(OP_FILTER, SAMPLE_W'(1));
        queue_item(OP_UPDATE, SAMPLE_MIN);
        queue_item(OP_FILTER, pick_sample(0));
        settle();

        // Writes to unused indexes must leave everything alone
        for (int s = int'(REG_SPARE_FIRST); s < CFG_INDEX_COUNT; s++)
            write_reg(CFG_INDEX_BITS'(s), $urandom);

        // Jump straight to the extreme targets and drive the output into saturation
        write_targets(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
        write_shift(0);
        queue_item(OP_UPDATE, pick_sample(0));
        queue_item(OP_FILTER, SAMPLE_MAX);
        queue_item(OP_FILTER, SAMPLE_MAX);
        queue_item(OP_FILTER, SAMPLE_MIN);
        queue_item(OP_FILTER, '0);
        settle();

        // Full-scale reversal: the step clips, then the coefficients clip
        write_targets(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
        queue_item(OP_UPDATE, pick_sample(0));
        queue_item(OP_FILTER, pick_sample(1));
        queue_item(OP_FILTER, pick_sample(1));
        queue_item(OP_FILTER, SAMPLE_MIN);
        settle();

        // Shifts above the nominal range
        write_targets(Q_ONE / 2, -(Q_ONE / 4), Q_ONE, -Q_ONE);
        write_shift(15);
        queue_item(OP_UPDATE, pick_sample(0));
        queue_item(OP_FILTER, pick_sample(1));
        queue_item(OP_FILTER, pick_sample(1));
        settle();
        write_shift(13);
        queue_item(OP_UPDATE, pick_sample(0));
        queue_item(OP_FILTER, pick_sample(0));
        queue_item(OP_FILTER, pick_sample(0));
        settle();

        // Random phases: a ramp start, then mostly samples with occasional re-ramps
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            configure_random();
            if (p == RANDOM_PHASES - 1)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 10;
                    default: send_idle_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0: recv_stall_pct = 0;
                    1: recv_stall_pct = 10;
                    default: recv_stall_pct = 35;
                endcase
            end
            mode = $urandom_range(0, 3);
            queue_item(OP_UPDATE, pick_sample(0));
            for (int n = 1; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 24) == 0)
                    queue_item(OP_UPDATE, pick_sample(0));
                else if ($urandom_range(0, 3) == 0)
                    queue_item(OP_FILTER, pick_sample(0));
                else
                    queue_item(OP_FILTER, pick_sample(mode));
            end
            if (p != RANDOM_PHASES - 1)
                settle();
        end

        // Drain the last results, then allow the pipeline to go quiet
        spins = 0;
        while ((items_in_flight != 0 || expected_samples.size() != 0) && spins < FINAL_WAIT_MAX)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (items_in_flight != 0 || expected_samples.size() != 0)
        begin
            errors += expected_samples.size() + items_in_flight;
            $display("%0t: %0d results never arrived, %0d items never taken",
                     $time, expected_samples.size(), items_in_flight);
        end

        $display("covered %0d filtered samples and %0d ramp starts", filtered_count, update_count);
        $display("over %0d target settings with %0d register writes", settings_count, reg_writes);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/rcbq_pkg.sv
rtl/core/rcbq_if.sv
rtl/core/rcbq_ramp.sv
rtl/core/rcbq_mac.sv
rtl/core/ramped_coefficient_biquad.sv
sim/testbench.sv
